### rtl/core/whp_pkg.sv
// package with transfer types, tag constants and status codes for the wav header parser
`timescale 1ns / 1ps

package whp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [4:0]  FMT_BODY_BYTES = 5'd16;
  localparam logic [4:0]  RIFF_HDR_BYTES = 5'd12;
  localparam logic [4:0]  CHUNK_HDR_BYTES = 5'd8;

  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] PCM_BITS = 16'd16;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TAG    = 2'd1,
    ST_EARLY_END  = 2'd2,
    ST_BAD_FORMAT = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_hz;
    logic [15:0] bit_depth;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } out_t;

endpackage

### rtl/core/wav_header_parser.sv
// top level: streaming riff/wave header parser, input register, parse step, result register
// a byte goes from the input register through the parse step, and its result into the result register
// throughput: one byte per cycle while the result side is not stalled
// rate is set by the single parse step between the input register and the result register
// reset: asynchronous active low, clears handshake state and returns the parser to the riff phase
`timescale 1ns / 1ps

module wav_header_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  whp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output whp_pkg::out_t out_data_o
);
  import whp_pkg::*;

  logic stage_valid;
  in_t  stage_data;
  logic out_free;
  logic step;
  logic res_valid;
  out_t res;

  assign step = stage_valid && out_free;

  whp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .valid_o    (stage_valid),
    .take_i     (step),
    .data_o     (stage_data)
  );

  whp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (stage_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  whp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/whp_in_stage.sv
// input register stage holding one byte transfer
`timescale 1ns / 1ps

module whp_in_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  whp_pkg::in_t in_data_i,
  output logic         valid_o,
  input  logic         take_i,
  output whp_pkg::in_t data_o
);
  import whp_pkg::*;

  logic valid_q;
  in_t  data_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

### rtl/core/whp_parse.sv
// header parse state and next-state logic, one byte per step
`timescale 1ns / 1ps

module whp_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  whp_pkg::in_t  item_i,
  output logic          res_valid_o,
  output whp_pkg::out_t res_o
);
  import whp_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HDR  = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_IDLE = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  count_q, count_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [32:0] skip_q, skip_d;
  logic [31:0] pos_q, pos_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;

  logic [7:0]  b;
  logic        res_v;
  status_e     res_st;
  logic [31:0] res_off;
  logic [31:0] res_len;
  logic        good;

  assign b = item_i.data_byte;

  always_comb begin
    // restart on first byte, then take the byte
    if (item_i.first_byte) begin
      phase_d = PH_RIFF;
      count_d = '0;
      tag_d   = '0;
      len_d   = '0;
      skip_d  = '0;
      pos_d   = '0;
      fmt_d   = '0;
      chan_d  = '0;
      rate_d  = '0;
      bits_d  = '0;
    end else begin
      phase_d = phase_q;
      count_d = count_q;
      tag_d   = tag_q;
      len_d   = len_q;
      skip_d  = skip_q;
      pos_d   = pos_q;
      fmt_d   = fmt_q;
      chan_d  = chan_q;
      rate_d  = rate_q;
      bits_d  = bits_q;
    end
    res_v   = 1'b0;
    res_st  = ST_OK;
    res_off = '0;
    res_len = '0;
    good    = 1'b0;
    pos_d   = pos_d + 32'd1;

    unique case (phase_d)
      PH_RIFF: begin
        if (count_d < 5'd4) begin
          tag_d = {tag_d[23:0], b};
        end else if (count_d >= 5'd8) begin
          len_d = {len_d[23:0], b};
        end
        count_d = count_d + 5'd1;
        if (count_d >= RIFF_HDR_BYTES) begin
          count_d = '0;
          if (tag_d == TAG_RIFF && len_d == TAG_WAVE) begin
            phase_d = PH_HDR;
          end else begin
            res_v   = 1'b1;
            res_st  = ST_BAD_TAG;
            phase_d = PH_IDLE;
          end
        end
      end
      PH_HDR: begin
        if (count_d < 5'd4) begin
          tag_d = {tag_d[23:0], b};
        end else begin
          len_d = {b, len_d[31:8]};
        end
        count_d = count_d + 5'd1;
        if (count_d >= CHUNK_HDR_BYTES) begin
          count_d = '0;
          if (tag_d == TAG_FMT) begin
            phase_d = PH_FMT;
          end else if (tag_d == TAG_DATA) begin
            good = fmt_d == FMT_PCM && (chan_d == 16'd1 || chan_d == 16'd2)
                   && bits_d == PCM_BITS;
            res_v   = 1'b1;
            res_st  = good ? ST_OK : ST_BAD_FORMAT;
            res_off = pos_d;
            res_len = len_d;
            phase_d = PH_IDLE;
          end else begin
            skip_d  = {1'b0, len_d} + {32'd0, len_d[0]};
            phase_d = (skip_d != '0) ? PH_SKIP : PH_HDR;
          end
        end
      end
      PH_FMT: begin
        case (count_d)
          5'd0:  fmt_d[7:0]    = b;
          5'd1:  fmt_d[15:8]   = b;
          5'd2:  chan_d[7:0]   = b;
          5'd3:  chan_d[15:8]  = b;
          5'd4:  rate_d[7:0]   = b;
          5'd5:  rate_d[15:8]  = b;
          5'd6:  rate_d[23:16] = b;
          5'd7:  rate_d[31:24] = b;
          5'd14: bits_d[7:0]   = b;
          5'd15: bits_d[15:8]  = b;
          default: ;
        endcase
        count_d = count_d + 5'd1;
        if (count_d >= FMT_BODY_BYTES) begin
          count_d = '0;
          // excess body bytes plus the pad byte of an odd length
          skip_d  = ((len_d > 32'd16) ? {1'b0, len_d - 32'd16} : 33'd0)
                    + {32'd0, len_d[0]};
          phase_d = (skip_d != '0) ? PH_SKIP : PH_HDR;
        end
      end
      PH_SKIP: begin
        if (skip_d != '0) begin
          skip_d = skip_d - 33'd1;
        end
        if (skip_d == '0) begin
          phase_d = PH_HDR;
        end
      end
      default: ;
    endcase

    if (!res_v && item_i.last_byte && phase_d != PH_IDLE) begin
      res_v   = 1'b1;
      res_st  = ST_EARLY_END;
      res_off = '0;
      res_len = '0;
      phase_d = PH_IDLE;
    end
  end

  assign res_valid_o         = step_i && res_v;
  assign res_o.ok            = (res_st == ST_OK);
  assign res_o.status        = res_st;
  assign res_o.audio_format  = fmt_d;
  assign res_o.channel_count = chan_d;
  assign res_o.sample_hz     = rate_d;
  assign res_o.bit_depth     = bits_d;
  assign res_o.data_offset   = res_off;
  assign res_o.data_length   = res_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      count_q <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      skip_q  <= '0;
      pos_q   <= '0;
      fmt_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      fmt_q   <= fmt_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
    end
  end

endmodule

### rtl/core/whp_out_stage.sv
// result register holding one result transfer
`timescale 1ns / 1ps

module whp_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  whp_pkg::out_t res_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output whp_pkg::out_t out_data_o
);
  import whp_pkg::*;

  logic valid_q;
  out_t data_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

endmodule
